// ===== rtl/core/reticle_bracket_overlay_blended_defines.svh =====
// ----------------------------------------------------------------------------
// Reticle overlay assertion macros
// Concurrent checks used by the overlay RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RETICLE_BRACKET_OVERLAY_BLENDED_DEFINES_SVH
`define RETICLE_BRACKET_OVERLAY_BLENDED_DEFINES_SVH
`ifndef SYNTHESIS
`define RBO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("overlay check failed");
`define RBO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("overlay check failed");
`else
`define RBO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RBO_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/rbo_pkg.sv =====
// ----------------------------------------------------------------------------
// Reticle overlay package
// Payload types, register indexes and the blend division step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rbo_pkg;

    localparam int NUM_RECTS = 13;
    localparam int NUM_BLENDS = 13;

    typedef enum logic [3:0] {
        CFG_ENABLE     = 4'd0,
        CFG_CENTER_XY  = 4'd1,
        CFG_RADIUS_XY  = 4'd2,
        CFG_VIEWPORT   = 4'd3,
        CFG_THICKNESS  = 4'd4,
        CFG_LENGTH     = 4'd5,
        CFG_SRC_COLOR  = 4'd6,
        CFG_CENTER_DOT = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [10:0] pixel_x;
        logic [9:0]  pixel_y;
        logic [31:0] dest_pixel;
    } in_t;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic [3:0]  cover_count;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  count;
        logic [31:0] pixel;
    } bld_t;

    typedef struct packed {
        logic [25:0] rem;
        logic [3:0]  q;
    } div_t;

    function automatic div_t div_step4(input logic [25:0] rem, input logic [16:0] dv,
                                       input logic [2:0] base);
        div_t r;
        logic [25:0] dd;
        r.rem = rem;
        r.q = 4'd0;
        for (int j = 3; j >= 0; j--) begin
            dd = 26'(dv) << (base + 3'(j));
            if (r.rem >= dd) begin
                r.rem = r.rem - dd;
                r.q[j] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rbo_blend.sv =====
// ----------------------------------------------------------------------------
// Reticle overlay blend unit
// One source-over blend in four stages; applied when the count exceeds IDX.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rbo_blend #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic [7:0]        sa,
    input  logic [2:0][23:0]  cs,
    input  rbo_pkg::bld_t     bin,
    output rbo_pkg::bld_t     bout
);
    import rbo_pkg::*;

    logic        a_v_reg, a_ap_reg;
    logic [3:0]  a_cnt_reg;
    logic [31:0] a_pix_reg;
    logic [15:0] a_m_reg, a_n_reg;

    logic        b_v_reg, b_ap_reg;
    logic [3:0]  b_cnt_reg;
    logic [31:0] b_pix_reg;
    logic [25:0] b_rem_reg [3];
    logic [16:0] b_d_reg;
    logic [7:0]  b_al_reg;

    logic        c_v_reg, c_ap_reg;
    logic [3:0]  c_cnt_reg;
    logic [31:0] c_pix_reg;
    logic [25:0] c_rem_reg [3];
    logic [3:0]  c_q_reg [3];
    logic [16:0] c_d_reg;
    logic [7:0]  c_al_reg;

    logic        d_v_reg;
    logic [3:0]  d_cnt_reg;
    logic [31:0] d_pix_reg;

    logic [7:0]  ia;
    logic [15:0] sa255, m_a, n_a;
    logic [16:0] x_al;
    logic [16:0] y_al;
    logic [25:0] num_b [3];
    div_t        dc_c [3];
    div_t        dc_d [3];
    logic [31:0] pix_d;

    always_comb begin
        ia    = 8'd255 - sa;
        sa255 = {sa, 8'd0} - 16'(sa);
        m_a   = 16'(bin.pixel[31:24]) * 16'(ia);
        n_a   = sa255 + m_a;
        x_al  = 17'(a_n_reg) + 17'd127;
        y_al  = x_al + 17'd1 + 17'(x_al[16:8]);
        for (int c = 0; c < 3; c++) begin
            num_b[c] = 26'(cs[c]) + 26'(a_pix_reg[c*8 +: 8]) * 26'(a_m_reg);
            num_b[c] = {num_b[c][24:0], 1'b0} + 26'(a_n_reg);
            dc_c[c]  = div_step4(b_rem_reg[c], b_d_reg, 3'd4);
            dc_d[c]  = div_step4(c_rem_reg[c], c_d_reg, 3'd0);
        end
        pix_d = {c_al_reg, c_q_reg[2], dc_d[2].q, c_q_reg[1], dc_d[1].q,
                 c_q_reg[0], dc_d[0].q};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end else if (ce) begin
            a_v_reg <= bin.valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_ap_reg  <= bin.count > 4'(IDX);
            a_cnt_reg <= bin.count;
            a_pix_reg <= bin.pixel;
            a_m_reg   <= m_a;
            a_n_reg   <= n_a;

            b_ap_reg  <= a_ap_reg;
            b_cnt_reg <= a_cnt_reg;
            b_pix_reg <= a_pix_reg;
            b_d_reg   <= {a_n_reg, 1'b0};
            b_al_reg  <= y_al[15:8];
            for (int c = 0; c < 3; c++) begin
                b_rem_reg[c] <= num_b[c];
            end

            c_ap_reg  <= b_ap_reg;
            c_cnt_reg <= b_cnt_reg;
            c_pix_reg <= b_pix_reg;
            c_d_reg   <= b_d_reg;
            c_al_reg  <= b_al_reg;
            for (int c = 0; c < 3; c++) begin
                c_rem_reg[c] <= dc_c[c].rem;
                c_q_reg[c]   <= dc_c[c].q;
            end

            d_cnt_reg <= c_cnt_reg;
            d_pix_reg <= c_ap_reg ? pix_d : c_pix_reg;
        end
    end

    assign bout.valid = d_v_reg;
    assign bout.count = d_cnt_reg;
    assign bout.pixel = d_pix_reg;

endmodule

// ===== rtl/core/reticle_bracket_overlay_blended.sv =====
// A pixel passes the input stages p0, p1 and p2 and then the thirteen chained
// four-stage blend units, each with a two-stage restoring divider; one pixel
// is accepted every cycle while the result is not stalled. A stalled result
// holds the whole pipeline. Configuration writes are taken at once; they are
// registered and then pass through the registered gate and rectangle bounds.
// ----------------------------------------------------------------------------
// Reticle overlay top level
// Bracket reticle coverage and repeated source-over blending of a pixel stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reticle_bracket_overlay_blended_defines.svh"
module reticle_bracket_overlay_blended #(
    parameter int FRAME_WIDTH   = 1280,
    parameter int FRAME_HEIGHT  = 720,
    parameter int MAX_THICKNESS = 16,
    parameter int MAX_LENGTH    = 100
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rbo_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rbo_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_index,
    input  logic [63:0]   cfg_data
);
    import rbo_pkg::*;

    localparam logic [12:0] FW_C = 13'(FRAME_WIDTH);
    localparam logic [12:0] FH_C = 13'(FRAME_HEIGHT);
    localparam logic [6:0]  MT_C = 7'(MAX_THICKNESS);
    localparam logic [7:0]  ML_C = 8'(MAX_LENGTH);

    logic        enable_reg, dot_reg;
    logic [21:0] center_reg;
    logic [23:0] radius_reg;
    logic [43:0] viewport_reg;
    logic [4:0]  thick_reg;
    logic [6:0]  length_reg;
    logic [31:0] src_reg;

    logic              gate_reg, dot_on_reg;
    logic [11:0]       vx0_reg, vx1_reg, vy0_reg, vy1_reg;
    logic signed [15:0] x0_reg [NUM_RECTS];
    logic signed [15:0] x1_reg [NUM_RECTS];
    logic signed [15:0] y0_reg [NUM_RECTS];
    logic signed [15:0] y1_reg [NUM_RECTS];
    logic [2:0][23:0]  cs_reg;
    logic [7:0]        sa_reg;

    logic        ce;
    logic        p0_v_reg;
    in_t         p0_reg;
    logic        p1_v_reg, p1_in_reg;
    logic [NUM_RECTS-1:0] p1_hit_reg;
    logic [31:0] p1_pix_reg;
    bld_t        chain [NUM_BLENDS+1];
    logic        p2_v_reg;
    logic [3:0]  p2_cnt_reg;
    logic [31:0] p2_pix_reg;

    logic [10:0] vl, vt, vw, vh, cxu, cyu;
    logic [12:0] vx1_w, vy1_w;
    logic        vp_ok, c_in;
    logic [6:0]  t_c;
    logic [7:0]  l_c;
    logic signed [15:0] cx, cy, rx, ry, ts, t2, hs, ls, cp;
    logic signed [15:0] lx, rxx, rcx, ty, by, bcy;
    logic signed [15:0] rx0 [NUM_RECTS];
    logic signed [15:0] ry0 [NUM_RECTS];
    logic signed [15:0] rw [NUM_RECTS];
    logic signed [15:0] rh [NUM_RECTS];
    logic signed [15:0] pxs, pys;
    logic [NUM_RECTS-1:0] hit;
    logic [NUM_RECTS-1:0] mask;
    logic [3:0]  cnt;
    logic [15:0] prod [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            center_reg   <= '0;
            radius_reg   <= '0;
            viewport_reg <= '0;
            thick_reg    <= 5'd1;
            length_reg   <= 7'd1;
            src_reg      <= '0;
            dot_reg      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENABLE:     enable_reg   <= cfg_data[0];
                CFG_CENTER_XY:  center_reg   <= cfg_data[21:0];
                CFG_RADIUS_XY:  radius_reg   <= cfg_data[23:0];
                CFG_VIEWPORT:   viewport_reg <= cfg_data[43:0];
                CFG_THICKNESS:  thick_reg    <= cfg_data[4:0];
                CFG_LENGTH:     length_reg   <= cfg_data[6:0];
                CFG_SRC_COLOR:  src_reg      <= cfg_data[31:0];
                CFG_CENTER_DOT: dot_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        vl  = viewport_reg[43:33];
        vt  = viewport_reg[32:22];
        vw  = viewport_reg[21:11];
        vh  = viewport_reg[10:0];
        cxu = center_reg[21:11];
        cyu = center_reg[10:0];
        vx1_w = 13'(vl) + 13'(vw);
        vy1_w = 13'(vt) + 13'(vh);
        vp_ok = (vw != 11'd0) && (vh != 11'd0) && (13'(vw) <= FW_C) && (13'(vh) <= FH_C)
                && (vx1_w <= FW_C) && (vy1_w <= FH_C);
        c_in  = (cxu >= vl) && (13'(cxu) < vx1_w) && (cyu >= vt) && (13'(cyu) < vy1_w);

        if (thick_reg == 5'd0) t_c = 7'd1;
        else if (7'(thick_reg) > MT_C) t_c = MT_C;
        else t_c = 7'(thick_reg);
        if (length_reg == 7'd0) l_c = 8'd1;
        else if (8'(length_reg) > ML_C) l_c = ML_C;
        else l_c = 8'(length_reg);

        cx = 16'(cxu);
        cy = 16'(cyu);
        rx = 16'(radius_reg[23:12]);
        ry = 16'(radius_reg[11:0]);
        ts = 16'(t_c);
        t2 = 16'(t_c[6:1]);
        ls = 16'(l_c);
        hs = 16'(l_c[7:1]);
        cp = (ts > hs) ? ts : hs;

        lx  = cx - rx - t2;
        rxx = cx + rx - t2;
        rcx = cx + rx - cp + t2;
        ty  = cy - ry - t2;
        by  = cy + ry - t2;
        bcy = cy + ry - cp + t2;

        rx0[0]  = lx;       ry0[0]  = cy - hs;      rw[0]  = ts; rh[0]  = ls;
        rx0[1]  = lx;       ry0[1]  = cy - hs;      rw[1]  = cp; rh[1]  = ts;
        rx0[2]  = lx;       ry0[2]  = cy + hs - ts; rw[2]  = cp; rh[2]  = ts;
        rx0[3]  = rxx;      ry0[3]  = cy - hs;      rw[3]  = ts; rh[3]  = ls;
        rx0[4]  = rcx;      ry0[4]  = cy - hs;      rw[4]  = cp; rh[4]  = ts;
        rx0[5]  = rcx;      ry0[5]  = cy + hs - ts; rw[5]  = cp; rh[5]  = ts;
        rx0[6]  = cx - hs;  ry0[6]  = ty;           rw[6]  = ls; rh[6]  = ts;
        rx0[7]  = cx - hs;  ry0[7]  = ty;           rw[7]  = ts; rh[7]  = cp;
        rx0[8]  = cx + hs - ts; ry0[8] = ty;        rw[8]  = ts; rh[8]  = cp;
        rx0[9]  = cx - hs;  ry0[9]  = by;           rw[9]  = ls; rh[9]  = ts;
        rx0[10] = cx - hs;  ry0[10] = bcy;          rw[10] = ts; rh[10] = cp;
        rx0[11] = cx + hs - ts; ry0[11] = bcy;      rw[11] = ts; rh[11] = cp;
        rx0[12] = cx - t2;  ry0[12] = cy - t2;      rw[12] = ts; rh[12] = ts;

        for (int c = 0; c < 3; c++) begin
            prod[c] = 16'(src_reg[c*8 +: 8]) * 16'(src_reg[31:24]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg   <= 1'b0;
            dot_on_reg <= 1'b0;
        end else begin
            gate_reg   <= enable_reg && (src_reg[31:24] != 8'd0) && vp_ok && c_in;
            dot_on_reg <= dot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        vx0_reg <= 12'(vl);
        vy0_reg <= 12'(vt);
        vx1_reg <= vx1_w[11:0];
        vy1_reg <= vy1_w[11:0];
        sa_reg  <= src_reg[31:24];
        for (int i = 0; i < NUM_RECTS; i++) begin
            x0_reg[i] <= rx0[i];
            x1_reg[i] <= rx0[i] + rw[i];
            y0_reg[i] <= ry0[i];
            y1_reg[i] <= ry0[i] + rh[i];
        end
        for (int c = 0; c < 3; c++) begin
            cs_reg[c] <= {prod[c], 8'd0} - 24'(prod[c]);
        end
    end

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    always_comb begin
        pxs = 16'(p0_reg.pixel_x);
        pys = 16'(p0_reg.pixel_y);
        for (int i = 0; i < NUM_RECTS; i++) begin
            hit[i] = (pxs >= x0_reg[i]) && (pxs < x1_reg[i]) &&
                     (pys >= y0_reg[i]) && (pys < y1_reg[i]);
        end
        mask = {dot_on_reg, {(NUM_RECTS-1){1'b1}}};
        cnt = 4'd0;
        for (int i = 0; i < NUM_RECTS; i++) begin
            cnt = cnt + 4'(p1_hit_reg[i] & mask[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end else if (ce) begin
            p0_v_reg <= s_valid;
            p1_v_reg <= p0_v_reg;
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p0_reg       <= s_data;
            p1_hit_reg   <= hit;
            p1_in_reg    <= (12'(p0_reg.pixel_x) >= vx0_reg) &&
                            (12'(p0_reg.pixel_x) < vx1_reg) &&
                            (12'(p0_reg.pixel_y) >= vy0_reg) &&
                            (12'(p0_reg.pixel_y) < vy1_reg);
            p1_pix_reg   <= p0_reg.dest_pixel;
            p2_cnt_reg   <= (gate_reg && p1_in_reg) ? cnt : 4'd0;
            p2_pix_reg   <= p1_pix_reg;
        end
    end

    assign chain[0] = '{valid: p2_v_reg, count: p2_cnt_reg, pixel: p2_pix_reg};

    for (genvar g = 0; g < NUM_BLENDS; g++) begin : g_blend
        rbo_blend #(.IDX(g)) u_blend (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .sa      (sa_reg),
            .cs      (cs_reg),
            .bin     (chain[g]),
            .bout    (chain[g+1])
        );
    end

    assign m_valid            = chain[NUM_BLENDS].valid;
    assign m_data.out_pixel   = chain[NUM_BLENDS].pixel;
    assign m_data.cover_count = chain[NUM_BLENDS].count;

    `RBO_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, p0_v_reg)
    `RBO_ASSERT_IMP(a_count_range, aclk, aresetn, m_valid, m_data.cover_count <= 4'd13)
    `RBO_ASSERT_IMP(a_blend_alpha, aclk, aresetn, m_valid && (m_data.cover_count != 4'd0),
                    m_data.out_pixel[31:24] != 8'd0)

endmodule
